### rtl/core/sorted_unique_key_table_unit_assert.svh
// Assertion macros used by the table engine RTL.
`ifndef SORTED_UNIQUE_KEY_TABLE_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_KEY_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define SUKT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sukt check failed");

// Next-cycle implication, sampled on clk and switched off during rst.
`define SUKT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sukt check failed");

`endif

### rtl/core/sukt_pkg.sv
`default_nettype none
package sukt_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int KEY_W    = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] out_key;
    logic                    found;
    logic [1:0]              status;
    logic                    last;
    logic [CNT_W-1:0]        count;
  } res_t;

endpackage
`default_nettype wire

### rtl/core/sukt_ifs.sv
`default_nettype none
interface sukt_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        cmd;
  logic signed [sukt_pkg::KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

interface sukt_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [sukt_pkg::KEY_W-1:0] out_key;
  logic                              found;
  logic [1:0]                        status;
  logic                              last;
  logic [sukt_pkg::CNT_W-1:0]        count;

  modport source (output valid, output out_key, output found, output status,
                  output last, output count, input ready);
  modport sink (input valid, input out_key, input found, input status,
                input last, input count, output ready);
endinterface
`default_nettype wire

### rtl/core/sukt_engine.sv
`default_nettype none
`include "sorted_unique_key_table_unit_assert.svh"
module sukt_engine (
  input  wire logic       clk,
  input  wire logic       rst,
  sukt_cmd_if.sink        cmd_ch,
  input  wire logic       res_free,
  output logic            res_valid,
  output sukt_pkg::res_t  res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_LIST = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  localparam logic [sukt_pkg::CNT_W-1:0] CAP_C = sukt_pkg::CNT_W'(sukt_pkg::CAPACITY);
  localparam logic [sukt_pkg::CNT_W-1:0] ONE_C = sukt_pkg::CNT_W'(1);

  logic signed [sukt_pkg::KEY_W-1:0] mem [sukt_pkg::CAPACITY];
  logic signed [sukt_pkg::KEY_W-1:0] rdata;

  logic [2:0]                        state;
  logic [1:0]                        cmd_r;
  logic signed [sukt_pkg::KEY_W-1:0] key_r;
  logic [sukt_pkg::CNT_W-1:0]        count;
  logic [sukt_pkg::CNT_W-1:0]        j;
  logic [sukt_pkg::CNT_W-1:0]        pos;
  logic                              rvalid;
  logic                              wpend;
  logic [sukt_pkg::ADDR_W-1:0]       waddr;
  logic                              found_r;
  logic [1:0]                        status_r;

  logic                              rd_en;
  logic [sukt_pkg::ADDR_W-1:0]       raddr;
  logic                              we;
  logic [sukt_pkg::ADDR_W-1:0]       wa;
  logic signed [sukt_pkg::KEY_W-1:0] wd;
  logic [sukt_pkg::CNT_W-1:0]        j_dec;
  logic                              hit;
  logic                              present;
  logic [sukt_pkg::CNT_W-1:0]        pos_f;
  logic                              advance;

  assign cmd_ch.ready = (state == S_IDLE);

  // The comparators of the block: stored key against the command key (>= and ==).
  assign j_dec   = j - ONE_C;
  assign hit     = rvalid && (rdata >= key_r);
  assign present = hit && (rdata == key_r);
  assign pos_f   = hit ? j_dec : count;
  assign advance = !rvalid || res_free;

  always_comb begin
    rd_en = 1'b0;
    raddr = j[sukt_pkg::ADDR_W-1:0];
    we    = 1'b0;
    wa    = waddr;
    wd    = rdata;
    unique case (state)
      S_SCAN: rd_en = (j < count);
      S_SHUP: begin
        rd_en = (j > pos);
        raddr = j_dec[sukt_pkg::ADDR_W-1:0];
        if (wpend) begin
          we = 1'b1;
        end else if (j == pos) begin
          we = 1'b1;
          wa = pos[sukt_pkg::ADDR_W-1:0];
          wd = key_r;
        end
      end
      S_SHDN: begin
        rd_en = (j < count);
        we    = wpend;
      end
      S_LIST: rd_en = advance && (j < count);
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_comb begin
    res_valid   = 1'b0;
    res.out_key = key_r;
    res.found   = found_r;
    res.status  = status_r;
    res.last    = 1'b1;
    res.count   = count;
    if (state == S_RESP) begin
      res_valid = res_free;
    end else if (state == S_LIST) begin
      res_valid   = rvalid && res_free;
      res.out_key = rdata;
      res.found   = 1'b0;
      res.status  = sukt_pkg::ST_DONE;
      res.last    = (j == count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rvalid <= 1'b0;
      wpend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_ch.valid) begin
            cmd_r  <= cmd_ch.cmd;
            key_r  <= cmd_ch.key;
            j      <= '0;
            rvalid <= 1'b0;
            if (cmd_ch.cmd != sukt_pkg::CMD_LIST) begin
              state <= S_SCAN;
            end else if (count != '0) begin
              state <= S_LIST;
            end
          end
        end
        S_SCAN: begin
          rvalid <= rd_en;
          if (rd_en) begin
            j <= j + ONE_C;
          end
          if (hit || (j == count)) begin
            rvalid <= 1'b0;
            wpend  <= 1'b0;
            pos    <= pos_f;
            found_r <= present;
            state  <= S_RESP;
            unique case (cmd_r)
              sukt_pkg::CMD_INSERT: begin
                if (present) begin
                  status_r <= sukt_pkg::ST_DUP;
                end else if (count >= CAP_C) begin
                  status_r <= sukt_pkg::ST_FULL;
                end else begin
                  status_r <= sukt_pkg::ST_DONE;
                  j        <= count;
                  state    <= S_SHUP;
                end
              end
              sukt_pkg::CMD_REMOVE: begin
                if (present) begin
                  status_r <= sukt_pkg::ST_DONE;
                  j        <= pos_f + ONE_C;
                  state    <= S_SHDN;
                end else begin
                  status_r <= sukt_pkg::ST_ABSENT;
                end
              end
              default: begin
                status_r <= present ? sukt_pkg::ST_DONE : sukt_pkg::ST_ABSENT;
              end
            endcase
          end
        end
        S_SHUP: begin
          wpend <= (j > pos);
          waddr <= j[sukt_pkg::ADDR_W-1:0];
          if (j > pos) begin
            j <= j_dec;
          end
          if (!wpend && (j == pos)) begin
            count <= count + ONE_C;
            state <= S_RESP;
          end
        end
        S_SHDN: begin
          wpend <= (j < count);
          waddr <= j_dec[sukt_pkg::ADDR_W-1:0];
          if (j < count) begin
            j <= j + ONE_C;
          end
          if (!wpend && (j >= count)) begin
            count <= count - ONE_C;
            state <= S_RESP;
          end
        end
        S_LIST: begin
          if (advance) begin
            rvalid <= rd_en;
            if (rd_en) begin
              j <= j + ONE_C;
            end
          end
          if (rvalid && res_free && (j == count)) begin
            state <= S_IDLE;
          end
        end
        S_RESP: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SUKT_ASSERT_NOW(a_count_cap, 1'b1, count <= CAP_C)
  `SUKT_ASSERT_NOW(a_wpend_shift, wpend, (state == S_SHUP) || (state == S_SHDN))
  `SUKT_ASSERT_NEXT(a_insert_grows, (state == S_SHUP) && !wpend && (j == pos),
                    count == $past(count) + ONE_C)
  `SUKT_ASSERT_NOW(a_result_room, res_valid, res_free)

endmodule
`default_nettype wire

### rtl/core/sorted_unique_key_table_unit.sv
// Channel  Role    Payload                                  Transfer
// cmd_ch   sink    cmd (2), key (32, signed)                valid && ready
// res_ch   source  out_key (32, signed), found, status (2), valid && ready
//                  last, count (7)
//
// A command transfer is followed by a scan from the bottom, one stored key per cycle through the
// one read port and key comparison. Insert shifts count - pos keys up and writes its key, remove
// shifts count - pos - 1 keys down. A response state then hands the status on; list gives one
// key per cycle while the output is not stalled, after the registered read. rst is synchronous
// and empties the table. A stalled output holds the sequencer in its response and list states;
// cmd_ch is ready only in idle.
`default_nettype none
module sorted_unique_key_table_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  sukt_cmd_if.sink   cmd_ch,
  sukt_res_if.source res_ch
);

  // Handshake between the sequencer and the output register: a result is
  // handed over only when the register is empty or being emptied this cycle.
  logic           res_free;
  logic           res_valid;
  sukt_pkg::res_t res;

  // The output register itself.
  logic           ovalid;
  sukt_pkg::res_t oreg;

  sukt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_free = !ovalid || res_ch.ready;

  // The register refills in the same cycle as a transfer leaves it, so a
  // list can stream one key per cycle while the sink keeps ready high.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (res_valid) begin
      ovalid <= 1'b1;
    end else if (res_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      oreg <= res;
    end
  end

  assign res_ch.valid   = ovalid;
  assign res_ch.out_key = oreg.out_key;
  assign res_ch.found   = oreg.found;
  assign res_ch.status  = oreg.status;
  assign res_ch.last    = oreg.last;
  assign res_ch.count   = oreg.count;

endmodule
`default_nettype wire
